// ===== src/cc20_pkg.sv =====
// shared types, constants and round functions for the chacha20 keystream xor block
// depends on nothing
package cc20_pkg;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;
    localparam int          DOUBLE_ROUNDS = 10;
    localparam int          FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_KEY_0        = 3'd0,
        REG_KEY_1        = 3'd1,
        REG_KEY_2        = 3'd2,
        REG_KEY_3        = 3'd3,
        REG_NONCE_LOW    = 3'd4,
        REG_NONCE_HIGH   = 3'd5,
        REG_START_CTR    = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    // one item on either side of the block
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_item;

    typedef logic [15:0][31:0] t_blk;

    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } t_core_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_core_sts;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input logic [31:0] a_i, input logic [31:0] b_i,
                                             input logic [31:0] c_i, input logic [31:0] d_i);
        logic [31:0] a, b, c, d;
        a = a_i; b = b_i; c = c_i; d = d_i;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {a, b, c, d};
    endfunction

    // column round then diagonal round
    function automatic t_blk double_round(input t_blk x_i);
        t_blk x;
        x = x_i;
        {x[0], x[4], x[8],  x[12]} = quarter(x[0], x[4], x[8],  x[12]);
        {x[1], x[5], x[9],  x[13]} = quarter(x[1], x[5], x[9],  x[13]);
        {x[2], x[6], x[10], x[14]} = quarter(x[2], x[6], x[10], x[14]);
        {x[3], x[7], x[11], x[15]} = quarter(x[3], x[7], x[11], x[15]);
        {x[0], x[5], x[10], x[15]} = quarter(x[0], x[5], x[10], x[15]);
        {x[1], x[6], x[11], x[12]} = quarter(x[1], x[6], x[11], x[12]);
        {x[2], x[7], x[8],  x[13]} = quarter(x[2], x[7], x[8],  x[13]);
        {x[3], x[4], x[9],  x[14]} = quarter(x[3], x[4], x[9],  x[14]);
        double_round = x;
    endfunction

endpackage

// ===== src/cc20_fifo.sv =====
// two-entry item queue used in front of and behind the xor engine
// depends on cc20_pkg
module cc20_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cc20_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output cc20_pkg::t_item o_item,
    output logic            o_empty
);
    localparam int PW = $clog2(cc20_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(cc20_pkg::FIFO_DEPTH + 1);

    cc20_pkg::t_item r_mem [cc20_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(cc20_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(cc20_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(cc20_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

// ===== src/cc20_core.sv =====
// iterative chacha20 block function, one double round per cycle
// depends on cc20_pkg
module cc20_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cc20_pkg::t_core_req i_req,
    input  logic [63:0]         i_key_0,
    input  logic [63:0]         i_key_1,
    input  logic [63:0]         i_key_2,
    input  logic [63:0]         i_key_3,
    input  logic [63:0]         i_nonce_low,
    input  logic [31:0]         i_nonce_high,
    output cc20_pkg::t_core_sts o_sts,
    output cc20_pkg::t_blk      o_block
);
    localparam int RW = $clog2(cc20_pkg::DOUBLE_ROUNDS);

    cc20_pkg::t_blk r_x, r_init, r_out, n_x, init_w, sum_w;
    logic [RW-1:0]  r_rnd;
    logic           r_busy, r_done;

    always_comb begin
        init_w = {i_nonce_high, i_nonce_low[63:32], i_nonce_low[31:0], i_req.counter,
                  i_key_3[63:32], i_key_3[31:0], i_key_2[63:32], i_key_2[31:0],
                  i_key_1[63:32], i_key_1[31:0], i_key_0[63:32], i_key_0[31:0],
                  cc20_pkg::SIGMA_3, cc20_pkg::SIGMA_2, cc20_pkg::SIGMA_1,
                  cc20_pkg::SIGMA_0};
        n_x = cc20_pkg::double_round(r_x);
        for (int w = 0; w < 16; w++) begin
            sum_w[w] = n_x[w] + r_init[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_x    <= init_w;
            r_init <= init_w;
        end else if (r_busy) begin
            r_x <= n_x;
        end
        if (r_busy && r_rnd == RW'(cc20_pkg::DOUBLE_ROUNDS - 1)) begin
            r_out <= sum_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                if (r_rnd == RW'(cc20_pkg::DOUBLE_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_rnd <= r_rnd + 1'b1;
            end
        end
    end

    assign o_sts   = '{done: r_done, busy: r_busy};
    assign o_block = r_out;
endmodule

// ===== src/cc20_back.sv =====
// xor engine: holds keystream block, counter and byte position, builds results
// depends on cc20_pkg, cc20_core
module cc20_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_empty,
    input  cc20_pkg::t_item i_in_item,
    output logic            o_in_pop,
    input  logic            i_out_full,
    output logic            o_out_push,
    output cc20_pkg::t_item o_out_item,
    input  logic [63:0]     i_key_0,
    input  logic [63:0]     i_key_1,
    input  logic [63:0]     i_key_2,
    input  logic [63:0]     i_key_3,
    input  logic [63:0]     i_nonce_low,
    input  logic [31:0]     i_nonce_high,
    input  logic [31:0]     i_start_counter
);
    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_RUN  = 3'b010,
        S_GEN  = 3'b100
    } t_state;

    t_state              r_state;
    cc20_pkg::t_item     r_item;
    logic [3:0]          r_cnt, r_idx;
    logic [63:0]         r_res;
    cc20_pkg::t_blk      r_blk;
    logic                r_bval, r_msg;
    logic [31:0]         r_ctr;
    logic [5:0]          r_pos;

    cc20_pkg::t_core_req core_req;
    cc20_pkg::t_core_sts core_sts;
    cc20_pkg::t_blk      core_blk;

    logic [3:0]  rem_item, n_bytes;
    logic [6:0]  rem_blk, pos_sum;
    logic [4:0]  idx_end;
    logic [63:0] mix;
    logic [511:0] ks_flat;
    logic        item_done;

    cc20_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (core_req),
        .i_key_0      (i_key_0),
        .i_key_1      (i_key_1),
        .i_key_2      (i_key_2),
        .i_key_3      (i_key_3),
        .i_nonce_low  (i_nonce_low),
        .i_nonce_high (i_nonce_high),
        .o_sts        (core_sts),
        .o_block      (core_blk)
    );

    always_comb begin
        ks_flat   = r_blk;
        rem_item  = r_cnt - r_idx;
        rem_blk   = 7'd64 - {1'b0, r_pos};
        n_bytes   = ({3'b0, rem_item} < rem_blk) ? rem_item : rem_blk[3:0];
        idx_end   = {1'b0, r_idx} + {1'b0, n_bytes};
        pos_sum   = {1'b0, r_pos} + {3'b0, n_bytes};
        item_done = (r_idx == r_cnt);
        mix       = r_res;
        for (int j = 0; j < 8; j++) begin
            logic [6:0] off;
            off = {1'b0, r_pos} + 7'(j) - {3'b0, r_idx};
            if (5'(j) >= {1'b0, r_idx} && 5'(j) < idx_end) begin
                mix[8*j +: 8] = r_item.data[8*j +: 8] ^ ks_flat[{off[5:0], 3'b000} +: 8];
            end
        end
        core_req.start   = (r_state == S_RUN) && !item_done && !r_bval;
        core_req.counter = r_ctr;
        o_in_pop   = (r_state == S_LOAD) && !i_in_empty;
        o_out_push = (r_state == S_RUN) && item_done && !i_out_full;
        o_out_item = '{data: r_res, count: r_item.count, last: r_item.last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_bval  <= 1'b0;
            r_msg   <= 1'b1;
            r_ctr   <= '0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (o_in_pop) begin
                        r_item  <= i_in_item;
                        r_cnt   <= (i_in_item.count > 4'd8) ? 4'd8 : i_in_item.count;
                        r_idx   <= '0;
                        r_res   <= '0;
                        r_state <= S_RUN;
                        if (r_msg) begin
                            // new message restarts the counter
                            r_ctr  <= i_start_counter;
                            r_pos  <= '0;
                            r_bval <= 1'b0;
                            r_msg  <= 1'b0;
                        end
                    end
                end
                S_RUN: begin
                    if (item_done) begin
                        if (!i_out_full) begin
                            r_state <= S_LOAD;
                            if (r_item.last) begin
                                r_pos  <= '0;
                                r_bval <= 1'b0;
                                r_msg  <= 1'b1;
                            end
                        end
                    end else if (!r_bval) begin
                        r_state <= S_GEN;
                    end else begin
                        r_res <= mix;
                        r_idx <= idx_end[3:0];
                        r_pos <= pos_sum[5:0];
                        if (pos_sum[6]) begin
                            r_bval <= 1'b0;
                            r_ctr  <= r_ctr + 32'd1;
                        end
                    end
                end
                S_GEN: begin
                    if (core_sts.done) begin
                        r_blk   <= core_blk;
                        r_bval  <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== src/chacha20_keystream_xor.sv =====
// top level of the chacha20 keystream xor block: registers, input queue,
// xor engine and result queue; depends on cc20_pkg, cc20_fifo, cc20_back
//
// Queue-style streaming ChaCha20 (RFC 8439) cipher: each transfer on the push
// side carries up to eight message bytes, little-endian, and one result
// transfer comes back per item with the bytes XORed against the keystream and
// unused bytes zeroed. Key, nonce and start counter are to be written by the
// user through the configuration port only while the block is idle; the
// block itself does not enforce this. Items pass a two-entry input queue,
// the xor engine and a two-entry result queue. The engine loads an item,
// works on it once per keystream block the item touches, then hands the
// result to the result queue, waiting while that queue is full, before it
// loads the next item. A new 64-byte keystream block is made in steps: start
// the block function, run ten double rounds at one per cycle, and take the
// finished block. The block function starts only when a keystream byte is
// needed, so key and nonce are sampled at that moment.
module chacha20_keystream_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_data_in,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_data_out,
    output logic [3:0]  o_byte_count_out,
    output logic        o_last_out
);
    logic [63:0] r_key_0, r_key_1, r_key_2, r_key_3, r_nonce_low;
    logic [31:0] r_nonce_high, r_start_ctr;

    cc20_pkg::t_item in_item, front_item, back_item, out_item;
    logic            front_empty, front_pop, back_full, back_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0      <= '0;
            r_key_1      <= '0;
            r_key_2      <= '0;
            r_key_3      <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
            r_start_ctr  <= '0;
        end else if (i_cfg_we) begin
            case (cc20_pkg::t_reg_idx'(i_cfg_idx))
                cc20_pkg::REG_KEY_0:      r_key_0      <= i_cfg_data;
                cc20_pkg::REG_KEY_1:      r_key_1      <= i_cfg_data;
                cc20_pkg::REG_KEY_2:      r_key_2      <= i_cfg_data;
                cc20_pkg::REG_KEY_3:      r_key_3      <= i_cfg_data;
                cc20_pkg::REG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                cc20_pkg::REG_NONCE_HIGH: r_nonce_high <= i_cfg_data[31:0];
                cc20_pkg::REG_START_CTR:  r_start_ctr  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{data: i_data_in, count: i_byte_count, last: i_last};

    // front: input queue, lets the pushing side run ahead of the engine
    cc20_fifo u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (front_pop),
        .o_item  (front_item),
        .o_empty (front_empty)
    );

    // back: keystream generation and xor
    cc20_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_empty      (front_empty),
        .i_in_item       (front_item),
        .o_in_pop        (front_pop),
        .i_out_full      (back_full),
        .o_out_push      (back_push),
        .o_out_item      (back_item),
        .i_key_0         (r_key_0),
        .i_key_1         (r_key_1),
        .i_key_2         (r_key_2),
        .i_key_3         (r_key_3),
        .i_nonce_low     (r_nonce_low),
        .i_nonce_high    (r_nonce_high),
        .i_start_counter (r_start_ctr)
    );

    // result queue, the engine keeps working while a result waits, until the queue is full
    cc20_fifo u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_item  (back_item),
        .o_full  (back_full),
        .i_pop   (pop),
        .o_item  (out_item),
        .o_empty (empty)
    );

    assign o_data_out       = out_item.data;
    assign o_byte_count_out = out_item.count;
    assign o_last_out       = out_item.last;
endmodule

// ===== src/cc20_checker.sv =====
// port-level checks for the chacha20 keystream xor block, bound to the top level
// depends on chacha20_keystream_xor ports only
module cc20_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_data_out,
    input logic [3:0]  o_byte_count_out
);
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (empty && !full))
        else $error("queues not empty after reset");

    a_zero_count_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_count_out == 4'd0) |-> o_data_out == 64'd0)
        else $error("zero count result carries data");

    a_one_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_count_out == 4'd1) |-> o_data_out[63:8] == 56'd0)
        else $error("bytes past count not zero");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_out)))
        else $error("waiting result changed");
endmodule

bind chacha20_keystream_xor cc20_checker u_cc20_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_data_out       (o_data_out),
    .o_byte_count_out (o_byte_count_out)
);
